// ===== src/cau_pkg.sv =====
// ============================================================================
// cau_pkg
// Shared widths, opcodes, pipeline word types and saturation helper for the
// complex arithmetic unit.
// ============================================================================
package cau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int MODE_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int PROD_W     = 2 * DATA_WIDTH;      // full product
  localparam int SUM_W      = PROD_W + 2;          // sum of two products, signed
  localparam int NUM_W      = PROD_W + FRAC_BITS;  // scaled dividend magnitude
  localparam int QUO_W      = DATA_WIDTH;          // quotient bits resolved by steps
  localparam int HI_W       = NUM_W - QUO_W;       // dividend bits used by precheck
  localparam int DIV_STAGES = QUO_W;

  localparam logic [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] DMIN = ~DMAX;

  typedef enum logic [MODE_W-1:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_SCALE   = 4'd3,
    OP_DIV     = 4'd4,
    OP_DIV_RE  = 4'd5,
    OP_NEG     = 4'd6,
    OP_CONJ    = 4'd7,
    OP_EQ      = 4'd8
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_SAT      = 2'd2
  } status_e;

  // operands plus all partial products
  typedef struct packed {
    logic [MODE_W-1:0]            mode;
    logic signed [DATA_WIDTH-1:0] ar;
    logic signed [DATA_WIDTH-1:0] ai;
    logic signed [DATA_WIDTH-1:0] br;
    logic signed [DATA_WIDTH-1:0] bi;
    logic signed [PROD_W-1:0]     p_arbr;
    logic signed [PROD_W-1:0]     p_aibi;
    logic signed [PROD_W-1:0]     p_aibr;
    logic signed [PROD_W-1:0]     p_arbi;
    logic signed [PROD_W-1:0]     p_brbr;
    logic signed [PROD_W-1:0]     p_bibi;
  } prod_t;

  // combined values, before saturation or division
  typedef struct packed {
    logic                     is_div;
    logic                     dz;
    logic                     eq;
    logic                     den_neg;
    logic signed [SUM_W-1:0]  raw_re;
    logic signed [SUM_W-1:0]  raw_im;
    logic [PROD_W-1:0]        den;
  } mix_t;

  // one divider lane
  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [QUO_W-1:0]  lo;
    logic [QUO_W-1:0]  quo;
    logic              neg;
    logic              ovf;
  } lane_t;

  // word carried through the divider stages
  typedef struct packed {
    logic                  is_div;
    logic                  eq;
    logic [STATUS_W-1:0]   status;
    logic [DATA_WIDTH-1:0] res_re;
    logic [DATA_WIDTH-1:0] res_im;
    logic [PROD_W-1:0]     den;
    lane_t                 lane_re;
    lane_t                 lane_im;
  } pw_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] val;
    logic                  ov;
  } sat_t;

  // clamp a wide signed value to the data range
  function automatic sat_t saturate(input logic signed [SUM_W-1:0] v);
    sat_t r;
    if ((v[SUM_W-1:DATA_WIDTH-1] == '0) || (v[SUM_W-1:DATA_WIDTH-1] == '1)) begin
      r.val = v[DATA_WIDTH-1:0];
      r.ov  = 1'b0;
    end else begin
      r.val = v[SUM_W-1] ? DMIN : DMAX;
      r.ov  = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== src/cau_mult.sv =====
// ============================================================================
// cau_mult
// First stage: registers the operands and all six signed partial products.
// ============================================================================
module cau_mult (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [cau_pkg::MODE_W-1:0]      mode_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_re_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_im_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_re_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_im_i,
  output logic                            valid_o,
  output cau_pkg::prod_t                  word_o
);
  import cau_pkg::*;

  prod_t word_d, word_q;
  logic  valid_q;

  // partial products
  always_comb begin
    word_d.mode   = mode_i;
    word_d.ar     = a_re_i;
    word_d.ai     = a_im_i;
    word_d.br     = b_re_i;
    word_d.bi     = b_im_i;
    word_d.p_arbr = a_re_i * b_re_i;
    word_d.p_aibi = a_im_i * b_im_i;
    word_d.p_aibr = a_im_i * b_re_i;
    word_d.p_arbi = a_re_i * b_im_i;
    word_d.p_brbr = b_re_i * b_re_i;
    word_d.p_bibi = b_im_i * b_im_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== src/cau_combine.sv =====
// ============================================================================
// cau_combine
// Second stage: decodes the opcode, forms sums, differences and the divisor.
// ============================================================================
module cau_combine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  cau_pkg::prod_t  word_i,
  output logic            valid_o,
  output cau_pkg::mix_t   word_o
);
  import cau_pkg::*;

  localparam int XW = SUM_W - DATA_WIDTH;
  localparam int PW = SUM_W - PROD_W;

  logic signed [SUM_W-1:0] ar_x, ai_x, br_x, bi_x;
  logic signed [SUM_W-1:0] arbr_x, aibi_x, aibr_x, arbi_x;
  logic signed [SUM_W-1:0] br_mag;
  mix_t word_d, word_q;
  logic valid_q;

  // sign extension to working width
  always_comb begin
    ar_x   = {{XW{word_i.ar[DATA_WIDTH-1]}}, word_i.ar};
    ai_x   = {{XW{word_i.ai[DATA_WIDTH-1]}}, word_i.ai};
    br_x   = {{XW{word_i.br[DATA_WIDTH-1]}}, word_i.br};
    bi_x   = {{XW{word_i.bi[DATA_WIDTH-1]}}, word_i.bi};
    arbr_x = {{PW{word_i.p_arbr[PROD_W-1]}}, word_i.p_arbr};
    aibi_x = {{PW{word_i.p_aibi[PROD_W-1]}}, word_i.p_aibi};
    aibr_x = {{PW{word_i.p_aibr[PROD_W-1]}}, word_i.p_aibr};
    arbi_x = {{PW{word_i.p_arbi[PROD_W-1]}}, word_i.p_arbi};
    br_mag = word_i.br[DATA_WIDTH-1] ? -br_x : br_x;
  end

  // opcode decode
  always_comb begin
    word_d.is_div  = 1'b0;
    word_d.dz      = 1'b0;
    word_d.eq      = 1'b0;
    word_d.den_neg = 1'b0;
    word_d.raw_re  = '0;
    word_d.raw_im  = '0;
    word_d.den     = '0;
    unique case (op_e'(word_i.mode))
      OP_ADD: begin
        word_d.raw_re = ar_x + br_x;
        word_d.raw_im = ai_x + bi_x;
      end
      OP_SUB: begin
        word_d.raw_re = ar_x - br_x;
        word_d.raw_im = ai_x - bi_x;
      end
      OP_MUL: begin
        word_d.raw_re = (arbr_x - aibi_x) >>> FRAC_BITS;
        word_d.raw_im = (aibr_x + arbi_x) >>> FRAC_BITS;
      end
      OP_SCALE: begin
        word_d.raw_re = arbr_x >>> FRAC_BITS;
        word_d.raw_im = aibr_x >>> FRAC_BITS;
      end
      OP_DIV: begin
        word_d.dz  = (word_i.br == '0) && (word_i.bi == '0);
        word_d.is_div = !word_d.dz;
        word_d.den = $unsigned(word_i.p_brbr) + $unsigned(word_i.p_bibi);
        if (!word_d.dz) begin
          word_d.raw_re = arbr_x + aibi_x;
          word_d.raw_im = aibr_x - arbi_x;
        end
      end
      OP_DIV_RE: begin
        word_d.dz      = (word_i.br == '0);
        word_d.is_div  = !word_d.dz;
        word_d.den_neg = word_i.br[DATA_WIDTH-1];
        word_d.den     = br_mag[PROD_W-1:0];
        if (!word_d.dz) begin
          word_d.raw_re = ar_x;
          word_d.raw_im = ai_x;
        end
      end
      OP_NEG: begin
        word_d.raw_re = -ar_x;
        word_d.raw_im = -ai_x;
      end
      OP_CONJ: begin
        word_d.raw_re = ar_x;
        word_d.raw_im = -ai_x;
      end
      OP_EQ: begin
        word_d.eq = (word_i.ar == word_i.br) && (word_i.ai == word_i.bi);
      end
      default: begin
        word_d.raw_re = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== src/cau_prep.sv =====
// ============================================================================
// cau_prep
// Third stage: saturates direct results; for division takes magnitudes,
// scales the dividend and checks whether the quotient needs more than QUO_W bits.
// ============================================================================
module cau_prep (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  cau_pkg::mix_t  word_i,
  output logic           valid_o,
  output cau_pkg::pw_t   word_o
);
  import cau_pkg::*;

  logic signed [SUM_W-1:0] mag_re, mag_im;
  logic [NUM_W-1:0]        num_re, num_im;
  logic [HI_W-1:0]         hi_re, hi_im;
  sat_t                    sat_re, sat_im;
  pw_t                     word_d, word_q;
  logic                    valid_q;

  // dividend magnitudes, scaled by the fraction
  always_comb begin
    mag_re = word_i.raw_re[SUM_W-1] ? -word_i.raw_re : word_i.raw_re;
    mag_im = word_i.raw_im[SUM_W-1] ? -word_i.raw_im : word_i.raw_im;
    num_re = {mag_re[PROD_W-1:0], {FRAC_BITS{1'b0}}};
    num_im = {mag_im[PROD_W-1:0], {FRAC_BITS{1'b0}}};
    hi_re  = num_re[NUM_W-1:QUO_W];
    hi_im  = num_im[NUM_W-1:QUO_W];
    sat_re = saturate(word_i.raw_re);
    sat_im = saturate(word_i.raw_im);
  end

  always_comb begin
    word_d.is_div = word_i.is_div;
    word_d.eq     = word_i.eq;
    word_d.res_re = sat_re.val;
    word_d.res_im = sat_im.val;
    word_d.den    = word_i.den;
    if (word_i.dz) begin
      word_d.status = ST_DIV_ZERO;
    end else if (sat_re.ov || sat_im.ov) begin
      word_d.status = ST_SAT;
    end else begin
      word_d.status = ST_OK;
    end
    // quotient of 2^QUO_W or more shows in the high dividend bits
    word_d.lane_re.rem = {{(PROD_W-HI_W){1'b0}}, hi_re};
    word_d.lane_re.lo  = num_re[QUO_W-1:0];
    word_d.lane_re.quo = '0;
    word_d.lane_re.neg = word_i.raw_re[SUM_W-1] ^ word_i.den_neg;
    word_d.lane_re.ovf = {{(PROD_W-HI_W){1'b0}}, hi_re} >= word_i.den;
    word_d.lane_im.rem = {{(PROD_W-HI_W){1'b0}}, hi_im};
    word_d.lane_im.lo  = num_im[QUO_W-1:0];
    word_d.lane_im.quo = '0;
    word_d.lane_im.neg = word_i.raw_im[SUM_W-1] ^ word_i.den_neg;
    word_d.lane_im.ovf = {{(PROD_W-HI_W){1'b0}}, hi_im} >= word_i.den;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== src/cau_div_step.sv =====
// ============================================================================
// cau_div_step
// One restoring division stage: resolves one quotient bit in each lane.
// ============================================================================
module cau_div_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  cau_pkg::pw_t  word_i,
  output logic          valid_o,
  output cau_pkg::pw_t  word_o
);
  import cau_pkg::*;

  pw_t  word_d, word_q;
  logic valid_q;

  function automatic lane_t step(input lane_t l, input logic [PROD_W-1:0] den);
    logic [PROD_W:0] t;
    logic [PROD_W:0] diff;
    logic            ge;
    lane_t           r;
    t      = {l.rem, l.lo[QUO_W-1]};
    diff   = t - {1'b0, den};
    ge     = t >= {1'b0, den};
    r      = l;
    r.rem  = ge ? diff[PROD_W-1:0] : t[PROD_W-1:0];
    r.lo   = {l.lo[QUO_W-2:0], 1'b0};
    r.quo  = {l.quo[QUO_W-2:0], ge};
    return r;
  endfunction

  // both lanes share the divisor
  always_comb begin
    word_d         = word_i;
    word_d.lane_re = step(word_i.lane_re, word_i.den);
    word_d.lane_im = step(word_i.lane_im, word_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== src/cau_finish.sv =====
// ============================================================================
// cau_finish
// Last stage: signs and saturates quotients, sets status, holds the output
// word for the receiver.
// ============================================================================
module cau_finish (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  cau_pkg::pw_t                      word_i,
  output logic                              valid_o,
  output logic [cau_pkg::DATA_WIDTH-1:0]    res_re_o,
  output logic [cau_pkg::DATA_WIDTH-1:0]    res_im_o,
  output logic                              is_equal_o,
  output logic [cau_pkg::STATUS_W-1:0]      status_o
);
  import cau_pkg::*;

  sat_t                  q_re, q_im;
  logic [DATA_WIDTH-1:0] res_re_d, res_im_d, res_re_q, res_im_q;
  logic [STATUS_W-1:0]   status_d, status_q;
  logic                  eq_q, valid_q;

  function automatic sat_t quo_out(input lane_t l);
    sat_t r;
    if (l.ovf) begin
      r.val = l.neg ? DMIN : DMAX;
      r.ov  = 1'b1;
    end else if (l.neg) begin
      // magnitude up to the most negative value fits
      if (l.quo[QUO_W-1] && (l.quo[QUO_W-2:0] != '0)) begin
        r.val = DMIN;
        r.ov  = 1'b1;
      end else begin
        r.val = -l.quo;
        r.ov  = 1'b0;
      end
    end else if (l.quo[QUO_W-1]) begin
      r.val = DMAX;
      r.ov  = 1'b1;
    end else begin
      r.val = l.quo;
      r.ov  = 1'b0;
    end
    return r;
  endfunction

  always_comb begin
    q_re = quo_out(word_i.lane_re);
    q_im = quo_out(word_i.lane_im);
    if (word_i.is_div) begin
      res_re_d = q_re.val;
      res_im_d = q_im.val;
      status_d = (q_re.ov || q_im.ov) ? ST_SAT : ST_OK;
    end else begin
      res_re_d = word_i.res_re;
      res_im_d = word_i.res_im;
      status_d = word_i.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      status_q <= status_d;
      eq_q     <= word_i.eq;
    end
  end

  assign valid_o    = valid_q;
  assign res_re_o   = res_re_q;
  assign res_im_o   = res_im_q;
  assign is_equal_o = eq_q;
  assign status_o   = status_q;

endmodule

// ===== src/complex_arithmetic_unit.sv =====
// ============================================================================
// complex_arithmetic_unit
// Pipelined complex ALU on signed Q16.16 operands.
// ============================================================================
// Usage:
//   Input channel: in_valid_i with mode_i and the four operand parts; a word
//   is taken at a clock edge where in_valid_i is high and in_stall_o is low.
//   Output channel: out_valid_o with res_re_o, res_im_o, is_equal_o and
//   status_o; a word leaves when out_valid_o is high and out_stall_i is low.
//   Every opcode passes one multiply stage, one decode stage, one divide
//   setup stage, 32 restoring divide stages (one quotient bit each) and
//   the output register. All opcodes travel the same path, so results
//   come out in order.
//   Throughput is one word per cycle; the divide stages set the depth.
//   While the output word is held by out_stall_i the whole pipeline freezes
//   and in_stall_o is raised in the same cycle; nothing is dropped or
//   repeated. Otherwise the unit takes a word every cycle.
//   Reset (rst_ni low) clears all valid bits; no result is pending after it.
// ============================================================================
module complex_arithmetic_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [cau_pkg::MODE_W-1:0]            mode_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_re_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_im_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_re_i,
  input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_im_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] res_re_o,
  output logic signed [cau_pkg::DATA_WIDTH-1:0] res_im_o,
  output logic                                  is_equal_o,
  output logic [cau_pkg::STATUS_W-1:0]          status_o
);
  import cau_pkg::*;

  logic                  adv;
  logic                  mult_v, comb_v;
  prod_t                 mult_w;
  mix_t                  comb_w;
  logic [DIV_STAGES:0]   chain_v;
  pw_t                   chain_w [DIV_STAGES+1];
  logic [DATA_WIDTH-1:0] res_re, res_im;

  // global advance: freeze only while the output word is held
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  cau_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .mode_i  (mode_i),
    .a_re_i  (a_re_i),
    .a_im_i  (a_im_i),
    .b_re_i  (b_re_i),
    .b_im_i  (b_im_i),
    .valid_o (mult_v),
    .word_o  (mult_w)
  );

  cau_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (mult_v),
    .word_i  (mult_w),
    .valid_o (comb_v),
    .word_o  (comb_w)
  );

  cau_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (comb_v),
    .word_i  (comb_w),
    .valid_o (chain_v[0]),
    .word_o  (chain_w[0])
  );

  // divider stages
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    cau_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (chain_v[g]),
      .word_i  (chain_w[g]),
      .valid_o (chain_v[g+1]),
      .word_o  (chain_w[g+1])
    );
  end

  cau_finish u_finish (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (chain_v[DIV_STAGES]),
    .word_i     (chain_w[DIV_STAGES]),
    .valid_o    (out_valid_o),
    .res_re_o   (res_re),
    .res_im_o   (res_im),
    .is_equal_o (is_equal_o),
    .status_o   (status_o)
  );

  assign res_re_o = $signed(res_re);
  assign res_im_o = $signed(res_im);

endmodule

// ===== src/cau_checker.sv =====
// ============================================================================
// cau_checker
// Port-level checks for the complex arithmetic unit, bound to the top level.
// ============================================================================
module cau_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic signed [cau_pkg::DATA_WIDTH-1:0] res_re_o,
  input logic signed [cau_pkg::DATA_WIDTH-1:0] res_im_o,
  input logic                                  is_equal_o,
  input logic [cau_pkg::STATUS_W-1:0]          status_o
);
  import cau_pkg::*;

  // a held output word keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(res_re_o) &&
    $stable(res_im_o) && $stable(status_o) && $stable(is_equal_o))
    else $error("output word changed while stalled");

  // input stalls only while the output word is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // status code three is never produced
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("illegal status code");

  // divide by zero gives zero parts
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_DIV_ZERO) |-> (res_re_o == '0) && (res_im_o == '0))
    else $error("divide by zero result not zero");

  // equality result carries zero parts and ok status
  a_eq_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_equal_o |->
    (res_re_o == '0) && (res_im_o == '0) && (status_o == ST_OK))
    else $error("equality result not clean");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
